### rtl/core/dsesc_pkg.sv
package dsesc_pkg;

	// Saturation point of the position counter
	localparam int MAX_TEXT_LEN = 65535;
	localparam int POS_W = 16;
	localparam logic [POS_W-1:0] POS_CAP =
		POS_W'((MAX_TEXT_LEN < 65535) ? MAX_TEXT_LEN : 65535);

	// Output queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_FAIL = 2'd2
	} kind_t;

	// One result word
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [POS_W-1:0] len;
		logic             run_end;
	} result_t;

	// Results of one decoded character: count is 0, 1 or 2
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} dec_out_t;

endpackage

### rtl/core/dsesc_decode.sv
module dsesc_decode import dsesc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] char_byte,
	input  logic       is_last,
	output dec_out_t   dec
);

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_BODY,
		PH_ESC,
		PH_HEX1,
		PH_DONE
	} phase_t;

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DOLLAR = 8'h24;

	phase_t           phase_q, phase_d;
	logic [3:0]       nibble_q, nibble_d;
	logic [POS_W-1:0] pos_q, pos_d;

	// Hex digit test; returns {valid, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

	// Byte for a named escape; zero for an unknown one
	function automatic logic [7:0] escape_byte(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h27: r = 8'h27;
			8'h24: r = 8'h24;
			8'h4E, 8'h6E, 8'h4C, 8'h6C: r = 8'h0A;
			8'h50, 8'h70: r = 8'h0C;
			8'h52, 8'h72: r = 8'h0D;
			8'h54, 8'h74: r = 8'h09;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic result_t mk(input kind_t k, input logic [7:0] b,
		input logic [POS_W-1:0] l);
		result_t r;
		r.kind    = k;
		r.data    = b;
		r.len     = l;
		r.run_end = 1'b0;
		return r;
	endfunction

	logic [4:0]       hex;
	logic [POS_W-1:0] pos_n;
	logic             ok;
	logic             was_done;
	logic [1:0]       n;
	result_t          r0, r1;

	// Decode one character against the current phase
	always_comb begin
		hex      = hex_value(char_byte);
		pos_n    = (pos_q < POS_CAP) ? pos_q + POS_W'(1) : pos_q;
		was_done = (phase_q == PH_DONE);
		ok       = 1'b0;
		n        = 2'd0;
		r0       = mk(KIND_DATA, 8'h00, '0);
		r1       = mk(KIND_DATA, 8'h00, '0);
		phase_d  = phase_q;
		nibble_d = nibble_q;
		pos_d    = pos_n;
		case (phase_q)
			PH_SEEK: begin
				if (char_byte == CH_QUOTE)
					phase_d = PH_BODY;
			end
			PH_BODY: begin
				if (char_byte == CH_QUOTE) begin
					r0      = mk(KIND_OK, 8'h00, pos_n);
					n       = 2'd1;
					phase_d = PH_DONE;
					ok      = 1'b1;
				end else if (char_byte == CH_DOLLAR) begin
					phase_d = PH_ESC;
				end else begin
					r0 = mk(KIND_DATA, char_byte, '0);
					n  = 2'd1;
				end
			end
			PH_ESC: begin
				if (hex[4]) begin
					nibble_d = hex[3:0];
					phase_d  = PH_HEX1;
				end else begin
					r0      = mk(KIND_DATA, escape_byte(char_byte), '0);
					n       = 2'd1;
					phase_d = PH_BODY;
				end
			end
			PH_HEX1: begin
				if (hex[4]) begin
					r0      = mk(KIND_DATA, {nibble_q, hex[3:0]}, '0);
					n       = 2'd1;
					phase_d = PH_BODY;
				end else begin
					// lone digit: zero byte, then the character as a body character
					r0      = mk(KIND_DATA, 8'h00, '0);
					n       = 2'd1;
					phase_d = PH_BODY;
					if (char_byte == CH_QUOTE) begin
						r1      = mk(KIND_OK, 8'h00, pos_n);
						n       = 2'd2;
						phase_d = PH_DONE;
						ok      = 1'b1;
					end else if (char_byte == CH_DOLLAR) begin
						phase_d = PH_ESC;
					end else begin
						r1 = mk(KIND_DATA, char_byte, '0);
						n  = 2'd2;
					end
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase

		// End of text: collapse to at most a single verdict and restart
		if (is_last) begin
			if (was_done) begin
				n = 2'd0;
			end else if (ok) begin
				r0 = mk(KIND_OK, 8'h00, pos_n);
				n  = 2'd1;
			end else begin
				r0 = mk(KIND_FAIL, 8'h00, '0);
				n  = 2'd1;
			end
			phase_d  = PH_SEEK;
			nibble_d = 4'd0;
			pos_d    = '0;
		end

		// Mark the last result of this character
		if (n == 2'd1)
			r0.run_end = 1'b1;
		if (n == 2'd2)
			r1.run_end = 1'b1;

		dec.count = n;
		dec.r0    = r0;
		dec.r1    = r1;
	end

	// Hold parse state; advance on each decoded character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEEK;
			nibble_q <= 4'd0;
			pos_q    <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			nibble_q <= nibble_d;
			pos_q    <= pos_d;
		end
	end

endmodule

### rtl/core/dsesc_queue.sv
module dsesc_queue import dsesc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  dec_out_t dec,
	output logic     room2,
	output logic     head_valid,
	input  logic     head_stall,
	output result_t  head
);

	result_t          mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       push_n;
	logic             pop;

	assign push_n     = push ? dec.count : 2'd0;
	assign head_valid = (cnt_q != '0);
	assign pop        = head_valid && !head_stall;
	assign room2      = (cnt_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign head       = mem[rp_q];

	// Write up to two words per cycle
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wp_q] <= dec.r0;
		if (push_n == 2'd2)
			mem[wp_q + PTR_W'(1)] <= dec.r1;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(push_n);
			if (pop)
				rp_q <= rp_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule

### rtl/core/dollar_escape_string_literal_parser.sv
// Dollar-escape string literal decoder. Feed the text one character per word
// with is_last on the final one; characters before the opening quote are
// skipped, escapes ($hh, $' $$ $N $L $P $R $T) are decoded, and each data byte
// comes out as a kind 0 word. The closing quote yields a kind 1 word with the
// consumed length; a text that ends without one yields a single kind 2 word,
// and the data bytes already delivered for it should be discarded. run_end
// marks the last word caused by each character. One character is taken every
// cycle while in_stall is low: it is registered, decoded once the queue has
// room and written, as zero to two words, into a four-entry output queue.
// The queue drains one word per cycle while out_stall is low, and in_stall
// rises only while the queue has fewer than two free entries.
module dollar_escape_string_literal_parser import dsesc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_byte,
	input  logic              is_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [7:0]        out_byte,
	output logic [POS_W-1:0]  consumed_length,
	output logic              run_end
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       room2;
	logic       advance;
	dec_out_t   dec;
	result_t    head;

	assign advance  = valid_s1 && room2;
	assign in_stall = valid_s1 && !room2;

	// Hold the accepted word until the queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_byte;
			last_s1 <= is_last;
		end
	end

	dsesc_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.char_byte (char_s1),
		.is_last   (last_s1),
		.dec       (dec)
	);

	dsesc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (advance),
		.dec        (dec),
		.room2      (room2),
		.head_valid (out_valid),
		.head_stall (out_stall),
		.head       (head)
	);

	// Drive the result word from the queue head
	assign kind            = head.kind;
	assign out_byte        = head.data;
	assign consumed_length = head.len;
	assign run_end         = head.run_end;

endmodule

### tb/tb_dollar_escape_string_literal_parser.sv
`timescale 1ns / 1ps

module tb_dollar_escape_string_literal_parser;
	import dsesc_pkg::*;

	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam int LONG_HOLD = 200;
	localparam int RANDOM_CHARS = 1200;
	localparam longint TIMEOUT_NS = 64'd10_000_000;

	typedef enum logic [2:0] {
		SCAN_SEEK,
		SCAN_BODY,
		SCAN_ESC,
		SCAN_HEX,
		SCAN_DONE
	} scan_t;

	// Decoder predictor and store of expected output words
	class literal_decoder_model;
		scan_t       phase;
		bit [3:0]    hi_nib;
		bit [15:0]   pos;
		result_t     step_words[$];
		result_t     pending_words[$];
		int          errors;

		function new();
			go_idle();
			errors = 0;
		endfunction

		function void go_idle();
			phase = SCAN_SEEK;
			hi_nib = '0;
			pos = '0;
		endfunction

		static function int hex_val(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c - "0");
			if (c >= "A" && c <= "F") return int'(c - "A") + 10;
			if (c >= "a" && c <= "f") return int'(c - "a") + 10;
			return -1;
		endfunction

		static function logic [7:0] escape_val(logic [7:0] c);
			case (c)
				CH_QUOTE:                return CH_QUOTE;
				CH_DOLLAR:               return CH_DOLLAR;
				"N", "n", "L", "l":      return 8'h0a;
				"P", "p":                return 8'h0c;
				"R", "r":                return 8'h0d;
				"T", "t":                return 8'h09;
				default:                 return 8'h00;
			endcase
		endfunction

		function void emit(kind_t k, logic [7:0] d, logic [15:0] l);
			result_t w;
			w.kind = k;
			w.data = d;
			w.len = l;
			w.run_end = 1'b0;
			step_words.push_back(w);
		endfunction

		// Handle one character inside the quotes; report a closing quote
		function bit body_char(logic [7:0] c);
			if (c == CH_QUOTE) begin
				emit(KIND_OK, 8'h00, pos);
				phase = SCAN_DONE;
				return 1'b1;
			end
			if (c == CH_DOLLAR) begin
				phase = SCAN_ESC;
				return 1'b0;
			end
			emit(KIND_DATA, c, 16'h0000);
			return 1'b0;
		endfunction

		// Note an accepted character and queue the words it should cause
		function void take_char(logic [7:0] c, logic last);
			bit was_done;
			bit closed;
			int h;
			was_done = (phase == SCAN_DONE);
			closed = 1'b0;
			step_words.delete();
			if (pos < POS_CAP) pos++;
			h = hex_val(c);
			case (phase)
				SCAN_SEEK: begin
					if (c == CH_QUOTE) phase = SCAN_BODY;
				end
				SCAN_BODY: closed = body_char(c);
				SCAN_ESC: begin
					if (h >= 0) begin
						hi_nib = h[3:0];
						phase = SCAN_HEX;
					end else begin
						emit(KIND_DATA, escape_val(c), 16'h0000);
						phase = SCAN_BODY;
					end
				end
				SCAN_HEX: begin
					if (h >= 0) begin
						emit(KIND_DATA, {hi_nib, h[3:0]}, 16'h0000);
						phase = SCAN_BODY;
					end else begin
						// lone digit: zero byte, then treat the character as body
						emit(KIND_DATA, 8'h00, 16'h0000);
						phase = SCAN_BODY;
						closed = body_char(c);
					end
				end
				default: phase = SCAN_DONE;
			endcase
			// End of text: one verdict word at most, then back to idle
			if (last) begin
				step_words.delete();
				if (!was_done) begin
					if (closed) emit(KIND_OK, 8'h00, pos);
					else emit(KIND_FAIL, 8'h00, 16'h0000);
				end
				go_idle();
			end
			if (step_words.size() > 0) step_words[step_words.size() - 1].run_end = 1'b1;
			foreach (step_words[i]) pending_words.push_back(step_words[i]);
		endfunction

		// Compare an accepted output word with the oldest expected one
		function void check_word(logic [1:0] k, logic [7:0] d, logic [15:0] l, logic re);
			result_t want;
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: kind %0d byte %02h len %0d end %0b",
						k, d, l, re);
				return;
			end
			want = pending_words.pop_front();
			if (k !== want.kind || d !== want.data || l !== want.len || re !== want.run_end)
			begin
				errors++;
				if (errors <= 10) begin
					$write("word mismatch: expected kind %0d byte %02h len %0d end %0b, ",
						want.kind, want.data, want.len, want.run_end);
					$display("got kind %0d byte %02h len %0d end %0b", k, d, l, re);
				end
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       char_byte;
	logic             is_last;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       kind;
	logic [7:0]       out_byte;
	logic [POS_W-1:0] consumed_length;
	logic             run_end;

	literal_decoder_model sb;
	logic [7:0] text_q[$];
	bit tx_burst;
	bit rx_burst;
	bit hold_req;

	dollar_escape_string_literal_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_byte       (char_byte),
		.is_last         (is_last),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.out_byte        (out_byte),
		.consumed_length (consumed_length),
		.run_end         (run_end)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Note accepted input words and check accepted output words
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.take_char(char_byte, is_last);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(kind, out_byte, consumed_length, run_end);
	end

	// Offer one character after a random gap and hold it until accepted
	task automatic send_char(logic [7:0] c, logic last);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= c;
		is_last <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_q();
		foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic send_str(string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
		send_q();
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return 8'h30 + 8'(v);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 10);
	endfunction

	// Build one random text, mostly well formed with random content
	function automatic void make_text();
		string pfx;
		string esc_set;
		int nseg;
		logic [7:0] c;
		pfx = "STRING#";
		esc_set = "'$NnLlPpRrTt";
		text_q.delete();
		// noise, biased towards the characters that matter
		if ($urandom_range(0, 9) == 0) begin
			nseg = $urandom_range(1, 12);
			for (int i = 0; i < nseg; i++) begin
				case ($urandom_range(0, 3))
					0: c = CH_QUOTE;
					1: c = CH_DOLLAR;
					2: c = hex_char();
					default: c = 8'($urandom_range(1, 255));
				endcase
				text_q.push_back(c);
			end
			return;
		end
		// type prefix or junk before the opening quote
		case ($urandom_range(0, 2))
			1: for (int i = 0; i < pfx.len(); i++) text_q.push_back(pfx[i]);
			2: begin
				nseg = $urandom_range(1, 4);
				for (int i = 0; i < nseg; i++) begin
					do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
					text_q.push_back(c);
				end
			end
			default: ;
		endcase
		text_q.push_back(CH_QUOTE);
		// body
		nseg = $urandom_range(0, 8);
		for (int i = 0; i < nseg; i++) begin
			case ($urandom_range(0, 5))
				2: begin
					text_q.push_back(CH_DOLLAR);
					text_q.push_back(esc_set[$urandom_range(0, 11)]);
				end
				3: begin
					text_q.push_back(CH_DOLLAR);
					text_q.push_back(hex_char());
					text_q.push_back(hex_char());
				end
				4: begin
					text_q.push_back(CH_DOLLAR);
					do c = 8'($urandom_range(1, 255));
					while (literal_decoder_model::hex_val(c) >= 0 ||
						literal_decoder_model::escape_val(c) != 8'h00);
					text_q.push_back(c);
				end
				5: begin
					text_q.push_back(CH_DOLLAR);
					text_q.push_back(hex_char());
					do c = 8'($urandom_range(1, 255));
					while (literal_decoder_model::hex_val(c) >= 0);
					text_q.push_back(c);
				end
				default: begin
					do c = 8'($urandom_range(1, 255));
					while (c == CH_QUOTE || c == CH_DOLLAR);
					text_q.push_back(c);
				end
			endcase
		end
		// ending: missing quote, open escape, closing quote, trailing junk
		case ($urandom_range(0, 5))
			0: ;
			1: begin
				text_q.push_back(CH_DOLLAR);
				if ($urandom_range(0, 1)) text_q.push_back(hex_char());
			end
			2, 3: text_q.push_back(CH_QUOTE);
			default: begin
				text_q.push_back(CH_QUOTE);
				nseg = $urandom_range(1, 3);
				for (int i = 0; i < nseg; i++) text_q.push_back(8'($urandom_range(1, 255)));
			end
		endcase
	endfunction

	// Receiver: random stall per word, bursts, and one long hold-off
	initial begin
		int w;
		int words;
		words = 0;
		rx_burst = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (words % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
			w = rx_burst ? 0 : $urandom_range(0, 18);
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			words++;
		end
	end

	// Stimulus
	initial begin
		int sent;
		int idx;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_byte = 8'h00;
		is_last = 1'b0;
		tx_burst = 1'b0;
		hold_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed texts: prefix, lone digit, unknown escape, trailing junk,
		// hex pairs, quote closed by the last character, missing quote,
		// text ending inside an escape
		send_str("x'$4g$Q$''y");
		send_str("'$aF$$\377'");
		send_str("'\001");
		send_str("'$");
		send_str("'$4");

		sent = 0;
		idx = 0;
		while (sent < RANDOM_CHARS) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			if (idx == 30) hold_req = 1'b1;
			if (idx >= 30 && idx < 40) tx_burst = 1'b1;
			// drain everything before going on
			if (idx == 70) begin
				in_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			make_text();
			send_q();
			sent += text_q.size();
			idx++;
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (32) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_dollar_escape_string_literal_parser OK");
		else
			$display("tb_dollar_escape_string_literal_parser NOT OK");
		$finish;
	end

	// Limit
	initial begin
		#(TIMEOUT_NS);
		$display("tb_dollar_escape_string_literal_parser NOT OK");
		$finish;
	end

endmodule

### dollar_escape_string_literal_parser.f
rtl/core/dsesc_pkg.sv
rtl/core/dsesc_decode.sv
rtl/core/dsesc_queue.sv
rtl/core/dollar_escape_string_literal_parser.sv
tb/tb_dollar_escape_string_literal_parser.sv
